// ----- rtl/core/ikc_pkg.sv -----
// ikc_pkg: shared types and constants for the image kernel convolution unit.
// No dependencies; every other file of the block except ikc_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ikc_pkg;

  localparam int unsigned MAX_KERNEL  = 7;
  localparam int unsigned KERN_AREA   = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned KSIZE_W     = 3;
  localparam int unsigned HEIGHT_W    = 13;
  localparam int unsigned WIDTH_W     = 11;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned COL_W       = 10;
  localparam int unsigned PROD_W      = 2 * PIX_W;
  localparam int unsigned ROWSUM_W    = PROD_W + 3;
  localparam int unsigned SUM_W       = 37;
  localparam int unsigned RPTR_W      = 3;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QPTR_W      = 3;
  localparam int unsigned QCNT_W      = 4;
  localparam int unsigned BUSY_W      = 2;
  localparam int unsigned CREDIT_W    = 5;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 32;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_HEIGHT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_KSIZE  = 2'd2;

  localparam logic MODE_COEF  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef pix_t [MAX_KERNEL-1:0][MAX_KERNEL-1:0] win_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [WIDTH_W-1:0]  width;
    logic [KSIZE_W-1:0]  ksize;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic [IDX_W-1:0]   coef_index;
    pix_t               value;
    logic [KSIZE_W-1:0] ksize;
    logic               emit;
    logic               last;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } job_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/ikc_if.sv -----
// ikc_in_if / ikc_out_if: valid/ready stream channels for requests and results.
// Depends on ikc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ikc_in_if;
  import ikc_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [IDX_W-1:0] coef_index;
  pix_t             value;
  modport source (output valid, mode, coef_index, value, input ready);
  modport sink   (input valid, mode, coef_index, value, output ready);
endinterface

interface ikc_out_if;
  import ikc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic signed [SUM_W-1:0] window_sum;
  logic                    last_of_frame;
  modport source (output valid, out_row, out_col, window_sum, last_of_frame, input ready);
  modport sink   (input valid, out_row, out_col, window_sum, last_of_frame, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ikc_ram.sv -----
// ikc_ram: generic single-port RAM, write-first not guaranteed, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ikc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/ikc_front.sv -----
// ikc_front: request intake, frame position tracking, line buffers and window.
// Depends on ikc_pkg and ikc_ram.
`timescale 1ns / 1ps
`default_nettype none

module ikc_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ikc_pkg::cfg_t              cfg_i,
  input  wire logic                       accept_i,
  input  wire logic                       mode_i,
  input  wire logic [ikc_pkg::IDX_W-1:0]  coef_index_i,
  input  wire ikc_pkg::pix_t              value_i,
  output ikc_pkg::job_t                   job_o,
  output logic                            job_valid_o,
  output ikc_pkg::win_t                   win_o,
  output logic [ikc_pkg::BUSY_W-1:0]      busy_o
);
  import ikc_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned CW1  = CW + 1;
  localparam int unsigned NROW = MAX_KERNEL;

  logic [HEIGHT_W-1:0] h_eff;
  logic [CW:0]         w_eff;
  logic [KSIZE_W-1:0]  k_eff;

  logic [ROW_W-1:0]    r_q;
  logic [CW-1:0]       c_q;
  logic [RPTR_W-1:0]   ptr_q;
  logic [HEIGHT_W-1:0] r_inc;
  logic [CW:0]         c_inc;
  logic                row_end, col_end, win_done;
  logic [ROW_W-1:0]    ctr_row;
  logic [CW-1:0]       ctr_col;
  job_t                job_d;

  logic                s1_v_q, s2_v_q;
  job_t                s1_q, s2_q;
  logic [RPTR_W-1:0]   s1_ptr_q;
  logic [PIX_W-1:0]    line_rd [NROW];
  pix_t                col_vec [NROW];
  win_t                win_q;

  // zero acts as one, oversize saturates
  always_comb begin
    if (cfg_i.height == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (cfg_i.height > HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_i.height;
    end
    if (cfg_i.width == '0) begin
      w_eff = CW1'(1);
    end else if (32'(cfg_i.width) > MAX_WIDTH) begin
      w_eff = CW1'(MAX_WIDTH);
    end else begin
      w_eff = CW1'(cfg_i.width);
    end
    if (cfg_i.ksize == '0) begin
      k_eff = KSIZE_W'(1);
    end else if (32'(cfg_i.ksize) > MAX_KERNEL) begin
      k_eff = KSIZE_W'(MAX_KERNEL);
    end else begin
      k_eff = cfg_i.ksize;
    end
  end

  assign r_inc    = {1'b0, r_q} + HEIGHT_W'(1);
  assign c_inc    = {1'b0, c_q} + CW1'(1);
  assign row_end  = r_inc >= h_eff;
  assign col_end  = c_inc >= w_eff;
  assign win_done = (r_inc >= HEIGHT_W'(k_eff)) && (c_inc >= CW1'(k_eff));
  // window centre = top-left + k/2
  assign ctr_row  = r_q + ROW_W'(k_eff >> 1) + ROW_W'(1) - ROW_W'(k_eff);
  assign ctr_col  = c_q + CW'(k_eff >> 1) + CW'(1) - CW'(k_eff);

  always_comb begin
    job_d.mode       = mode_i;
    job_d.coef_index = coef_index_i;
    job_d.value      = value_i;
    job_d.ksize      = k_eff;
    job_d.emit       = (mode_i == MODE_PIXEL) && win_done;
    job_d.last       = row_end && col_end;
    job_d.row        = ctr_row;
    job_d.col        = COL_W'(ctr_col);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q   <= '0;
      c_q   <= '0;
      ptr_q <= '0;
    end else if (accept_i) begin
      if (mode_i == MODE_COEF) begin
        r_q   <= '0;
        c_q   <= '0;
        ptr_q <= '0;
      end else if (col_end) begin
        c_q <= '0;
        if (row_end) begin
          r_q   <= '0;
          ptr_q <= '0;
        end else begin
          r_q   <= r_inc[ROW_W-1:0];
          ptr_q <= (ptr_q == RPTR_W'(NROW - 1)) ? '0 : ptr_q + RPTR_W'(1);
        end
      end else begin
        c_q <= c_inc[CW-1:0];
      end
    end
  end

  // one line buffer per ring row; all rows are read at the current column
  for (genvar g = 0; g < NROW; g++) begin : g_line
    ikc_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (accept_i && (mode_i == MODE_PIXEL) && (ptr_q == RPTR_W'(g))),
      .addr_i  (c_q),
      .wdata_i (value_i),
      .rdata_o (line_rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q     <= job_d;
      s1_ptr_q <= ptr_q;
    end
    if (s1_v_q) begin
      s2_q <= s1_q;
    end
  end

  // column vector: age 0 is the new pixel, age b is ring row ptr-b
  always_comb begin
    logic [RPTR_W-1:0] idx;
    col_vec[0] = s1_q.value;
    for (int b = 1; b < NROW; b++) begin
      idx = (s1_ptr_q >= RPTR_W'(b)) ? s1_ptr_q - RPTR_W'(b)
                                     : s1_ptr_q + RPTR_W'(NROW - b);
      col_vec[b] = '0;
      for (int g = 0; g < NROW; g++) begin
        if (idx == RPTR_W'(g)) begin
          col_vec[b] = line_rd[g];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && (s1_q.mode == MODE_PIXEL)) begin
      for (int b = 0; b < NROW; b++) begin
        win_q[b][0] <= col_vec[b];
        for (int a = 1; a < NROW; a++) begin
          win_q[b][a] <= win_q[b][a-1];
        end
      end
    end
  end

  assign job_o       = s2_q;
  assign job_valid_o = s2_v_q;
  assign win_o       = win_q;
  assign busy_o      = BUSY_W'(s1_v_q && s1_q.emit) + BUSY_W'(s2_v_q && s2_q.emit);

endmodule

`default_nettype wire

// ----- rtl/core/ikc_mac.sv -----
// ikc_mac: kernel store, 49 parallel products and a registered adder tree.
// Depends on ikc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ikc_mac (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ikc_pkg::job_t          job_i,
  input  wire logic                   job_valid_i,
  input  wire ikc_pkg::win_t          win_i,
  output ikc_pkg::res_t               res_o,
  output logic                        res_valid_o,
  output logic [ikc_pkg::BUSY_W-1:0]  busy_o
);
  import ikc_pkg::*;

  pix_t                       kernel_q [KERN_AREA];
  pix_t                       coef [MAX_KERNEL][MAX_KERNEL];
  logic signed [PROD_W-1:0]   prod_q [MAX_KERNEL][MAX_KERNEL];
  logic signed [ROWSUM_W-1:0] rowsum_d [MAX_KERNEL];
  logic signed [ROWSUM_W-1:0] rowsum_q [MAX_KERNEL];
  logic signed [SUM_W-1:0]    total_d;
  logic                       va_q, vb_q, vc_q;
  job_t                       ma_q, mb_q;
  res_t                       res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KERN_AREA; i++) begin
        kernel_q[i] <= '0;
      end
    end else if (job_valid_i && (job_i.mode == MODE_COEF)
                 && (32'(job_i.coef_index) < KERN_AREA)) begin
      kernel_q[job_i.coef_index] <= job_i.value;
    end
  end

  // window age (b,a) meets kernel (k-1-b, k-1-a); outside the k x k square it is zero
  for (genvar gb = 0; gb < MAX_KERNEL; gb++) begin : g_row
    for (genvar ga = 0; ga < MAX_KERNEL; ga++) begin : g_col
      always_comb begin
        coef[gb][ga] = '0;
        for (int kk = 1; kk <= MAX_KERNEL; kk++) begin
          if ((kk > gb) && (kk > ga) && (job_i.ksize == KSIZE_W'(kk))) begin
            coef[gb][ga] = kernel_q[(kk-1-gb)*MAX_KERNEL + (kk-1-ga)];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < MAX_KERNEL; b++) begin
      for (int a = 0; a < MAX_KERNEL; a++) begin
        prod_q[b][a] <= PROD_W'(win_i[b][a]) * PROD_W'(coef[b][a]);
      end
    end
    ma_q <= job_i;
  end

  always_comb begin
    for (int b = 0; b < MAX_KERNEL; b++) begin
      rowsum_d[b] = '0;
      for (int a = 0; a < MAX_KERNEL; a++) begin
        rowsum_d[b] = rowsum_d[b] + ROWSUM_W'(prod_q[b][a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rowsum_q <= rowsum_d;
    mb_q     <= ma_q;
  end

  always_comb begin
    total_d = '0;
    for (int b = 0; b < MAX_KERNEL; b++) begin
      total_d = total_d + SUM_W'(rowsum_q[b]);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.row  <= mb_q.row;
    res_q.col  <= mb_q.col;
    res_q.sum  <= total_d;
    res_q.last <= mb_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= job_valid_i && (job_i.mode == MODE_PIXEL) && job_i.emit;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = vc_q;
  assign busy_o      = BUSY_W'(va_q) + BUSY_W'(vb_q) + BUSY_W'(vc_q);

endmodule

`default_nettype wire

// ----- rtl/core/ikc_fifo.sv -----
// ikc_fifo: short result queue that decouples the compute pipe from the sink.
// Depends on ikc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ikc_fifo (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire ikc_pkg::res_t          data_i,
  input  wire logic                   pop_i,
  output logic                        valid_o,
  output ikc_pkg::res_t               data_o,
  output logic [ikc_pkg::QCNT_W-1:0]  count_o
);
  import ikc_pkg::*;

  res_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCNT_W'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with empty count");

endmodule

`default_nettype wire

// ----- rtl/core/image_kernel_convolution_unit.sv -----
// image_kernel_convolution_unit: top level, APB register file and credit control.
// Depends on ikc_pkg, ikc_if, ikc_front, ikc_mac, ikc_fifo (and ikc_ram below).
//
// Usage:
//   pix_i carries requests: mode 0 loads kernel coefficient coef_index (row*7+col)
//   and restarts the frame position; mode 1 is one pixel in raster order.
//   res_o carries one result per pixel that completes a k x k window: the sum of
//   products, the window centre row/col and a last-of-frame flag.
//   Registers (APB, byte address 4*i): image_height, image_width, kernel_size.
//   Write them only while no request is in flight.
// Timing:
//   One request per cycle sustained while pix_i.ready is high. A result becomes
//   visible after its pixel is accepted: the line-buffer read is issued at the
//   accepting edge, then the window shift, the 49 parallel multiplies, the row
//   sums, the final sum and the queue write are each registered in that order.
//   pix_i.ready drops only when the 8-entry result queue plus the results still
//   in the pipe would fill it, i.e. when res_o is stalled.
// Reset:
//   Registers return to 8/8/3, the kernel is cleared, the frame position is
//   zero and the queue is empty. Line buffers are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module image_kernel_convolution_unit #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ikc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ikc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ikc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  ikc_in_if.sink                              pix_i,
  ikc_out_if.source                           res_o
);
  import ikc_pkg::*;

  cfg_t                cfg_q;
  logic                accept;
  job_t                job;
  logic                job_valid;
  win_t                win;
  logic [BUSY_W-1:0]   busy_f, busy_m;
  res_t                mac_res;
  logic                mac_valid;
  res_t                q_data;
  logic                q_valid;
  logic [QCNT_W-1:0]   q_count;
  logic [CREDIT_W-1:0] credit;

  // ---- configuration port: writes land in the access phase ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.height <= HEIGHT_W'(8);
      cfg_q.width  <= WIDTH_W'(8);
      cfg_q.ksize  <= KSIZE_W'(3);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_HEIGHT: cfg_q.height <= pwdata[HEIGHT_W-1:0];
        REG_WIDTH:  cfg_q.width  <= pwdata[WIDTH_W-1:0];
        REG_KSIZE:  cfg_q.ksize  <= pwdata[KSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HEIGHT: prdata = APB_DATA_W'(cfg_q.height);
      REG_WIDTH:  prdata = APB_DATA_W'(cfg_q.width);
      REG_KSIZE:  prdata = APB_DATA_W'(cfg_q.ksize);
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // ---- intake: a request is taken only when its result has a queue slot ----
  assign credit      = CREDIT_W'(q_count) + CREDIT_W'(busy_f) + CREDIT_W'(busy_m);
  assign pix_i.ready = credit < CREDIT_W'(QUEUE_DEPTH);
  assign accept      = pix_i.valid && pix_i.ready;

  ikc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .mode_i       (pix_i.mode),
    .coef_index_i (pix_i.coef_index),
    .value_i      (pix_i.value),
    .job_o        (job),
    .job_valid_o  (job_valid),
    .win_o        (win),
    .busy_o       (busy_f)
  );

  ikc_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .win_i       (win),
    .res_o       (mac_res),
    .res_valid_o (mac_valid),
    .busy_o      (busy_m)
  );

  // ---- back end: result queue feeding the output channel ----
  ikc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mac_valid),
    .data_i  (mac_res),
    .pop_i   (res_o.valid && res_o.ready),
    .valid_o (q_valid),
    .data_o  (q_data),
    .count_o (q_count)
  );

  assign res_o.valid         = q_valid;
  assign res_o.out_row       = q_data.row;
  assign res_o.out_col       = q_data.col;
  assign res_o.window_sum    = q_data.sum;
  assign res_o.last_of_frame = q_data.last;

  // queued plus in-flight results never exceed the queue
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit <= CREDIT_W'(QUEUE_DEPTH))
    else $error("result credit exceeds queue depth");

endmodule

`default_nettype wire
